>>> sv/tts_pkg.sv
// Shared types, widths and constants of the triangle tangent-space block.
package tts_pkg;

  localparam int CW    = 32;  // input coordinate width
  localparam int DW    = 33;  // difference width, also multiplier operand width
  localparam int PW    = 2 * DW;  // product width
  localparam int VW    = PW + 1;  // combined vector component width
  localparam int OW    = 16;  // Q2.14 output component width
  localparam int RW    = 30;  // normalised magnitude width
  localparam int SUMW  = 2 * RW + 2;  // sum of three squares
  localparam int LENW  = RW + 1;  // vector length width
  localparam int FRACW = 14;  // fraction bits of Q2.14
  localparam int NUMW  = LENW + OW - 1;  // quotient numerator and shifted divisor
  localparam int UNIT  = 16384;

  localparam int NPROD_TB  = 14;  // products for det, T and B
  localparam int NPROD_ALL = 20;  // plus the products of the normal
  localparam int NRES      = 10;  // det, T, B, N components
  localparam int PCW       = 5;
  localparam int RIW       = 4;

  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [OW-1:0] comp_t;

  typedef struct packed {
    diff_t a;
    diff_t b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } norm_stat_t;

endpackage

>>> sv/triangle_tangent_space.sv
// The first and second vertex of a triangle are stored and give no word.
// Third vertex: the products for det, T and B, then three normalisations (T, B and the
// normal, with the products of the normal before its own), each with a variable shift.
// A zero determinant skips the normalisations and gives a degenerate word.
// Throughput: one triangle at a time; the shared multiplier and the normaliser set it.
// Reset (rst_n low, synchronous): sequencer idle, vertex slot 0, no result word pending.
module triangle_tangent_space (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v (32 bits each, from bit 0 up)
  input  logic [159:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // tangent_x/y/z, bitangent_x/y/z, face_normal_x/y/z (16 bits each, from bit 0 up)
  output logic [143:0]  out_tdata,
  // degenerate
  output logic          out_tuser
);
  import tts_pkg::*;

  typedef enum logic [6:0] {
    T_IDLE   = 7'b0000001,
    T_PROD   = 7'b0000010,
    T_NORM_T = 7'b0000100,
    T_NORM_B = 7'b0001000,
    T_PROD_N = 7'b0010000,
    T_NORM_N = 7'b0100000,
    T_FINISH = 7'b1000000
  } tstate_t;

  tstate_t              state_r;
  logic [1:0]           slot_r;
  logic [CW-1:0]        hp_r [6];
  logic [CW-1:0]        ht_r [4];
  diff_t                e1_r [3];
  diff_t                e2_r [3];
  diff_t                du1_r, dv1_r, du2_r, dv2_r;
  logic [PCW-1:0]       pc_r;
  logic                 pv_r;
  logic [PCW-1:0]       pidx_r;
  vec_t                 acc_r;
  vec_t                 w_r [NRES];
  comp_t                t_r [3];
  comp_t                b_r [3];
  comp_t                n_r [3];
  logic                 degen_r;
  logic                 nstart_r;
  logic                 out_tvalid_r;
  logic [143:0]         out_tdata_r;
  logic                 out_tuser_r;

  logic signed [CW-1:0] f_pos [3];
  logic signed [CW-1:0] f_u, f_v;
  logic signed [PW-1:0] prod;
  mul_req_t             seq_req, norm_req, mul_req;
  norm_stat_t           nstat;
  comp_t                nq [3];
  vec_t                 nvin [3];
  logic                 nflip;
  logic                 issue;
  logic                 norm_busy;
  logic                 accept;
  logic                 load_out;
  logic                 nstart_nxt;

  assign f_pos[0] = in_tdata[31:0];
  assign f_pos[1] = in_tdata[63:32];
  assign f_pos[2] = in_tdata[95:64];
  assign f_u      = in_tdata[127:96];
  assign f_v      = in_tdata[159:128];

  assign in_tready = (state_r == T_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign norm_busy = (state_r == T_NORM_T) || (state_r == T_NORM_B) || (state_r == T_NORM_N);

  // issue one product per cycle until the end of the current product run
  assign issue = ((state_r == T_PROD) && (pc_r != PCW'(NPROD_TB))) ||
                 ((state_r == T_PROD_N) && (pc_r != PCW'(NPROD_ALL)));

  // start the normaliser once the vector it needs is stored
  assign nstart_nxt = ((state_r == T_PROD) && !issue && (w_r[0] != '0)) ||
                      ((state_r == T_NORM_T) && nstat.done && !nstat.zero) ||
                      ((state_r == T_PROD_N) && !issue);

  // operand pairs: even index loads the accumulator, odd index subtracts and stores the pair
  always_comb begin
    seq_req.a = '0;
    seq_req.b = '0;
    unique case (pc_r)
      5'd0:  begin seq_req.a = du1_r; seq_req.b = dv2_r; end
      5'd1:  begin seq_req.a = du2_r; seq_req.b = dv1_r; end
      5'd2:  begin seq_req.a = dv2_r; seq_req.b = e1_r[0]; end
      5'd3:  begin seq_req.a = dv1_r; seq_req.b = e2_r[0]; end
      5'd4:  begin seq_req.a = dv2_r; seq_req.b = e1_r[1]; end
      5'd5:  begin seq_req.a = dv1_r; seq_req.b = e2_r[1]; end
      5'd6:  begin seq_req.a = dv2_r; seq_req.b = e1_r[2]; end
      5'd7:  begin seq_req.a = dv1_r; seq_req.b = e2_r[2]; end
      5'd8:  begin seq_req.a = du1_r; seq_req.b = e2_r[0]; end
      5'd9:  begin seq_req.a = du2_r; seq_req.b = e1_r[0]; end
      5'd10: begin seq_req.a = du1_r; seq_req.b = e2_r[1]; end
      5'd11: begin seq_req.a = du2_r; seq_req.b = e1_r[1]; end
      5'd12: begin seq_req.a = du1_r; seq_req.b = e2_r[2]; end
      5'd13: begin seq_req.a = du2_r; seq_req.b = e1_r[2]; end
      5'd14: begin seq_req.a = DW'(t_r[1]); seq_req.b = DW'(b_r[2]); end
      5'd15: begin seq_req.a = DW'(t_r[2]); seq_req.b = DW'(b_r[1]); end
      5'd16: begin seq_req.a = DW'(t_r[2]); seq_req.b = DW'(b_r[0]); end
      5'd17: begin seq_req.a = DW'(t_r[0]); seq_req.b = DW'(b_r[2]); end
      5'd18: begin seq_req.a = DW'(t_r[0]); seq_req.b = DW'(b_r[1]); end
      5'd19: begin seq_req.a = DW'(t_r[1]); seq_req.b = DW'(b_r[0]); end
      default: begin seq_req.a = '0; seq_req.b = '0; end
    endcase
  end

  assign mul_req = norm_busy ? norm_req : seq_req;

  tts_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod)
  );

  // vector handed to the normaliser: T, B, then the normal
  always_comb begin
    nflip = 1'b0;
    for (int i = 0; i < 3; i++) nvin[i] = w_r[7 + i];
    priority if (state_r == T_NORM_T) begin
      nflip = w_r[0][VW-1];
      for (int i = 0; i < 3; i++) nvin[i] = w_r[1 + i];
    end else if (state_r == T_NORM_B) begin
      nflip = w_r[0][VW-1];
      for (int i = 0; i < 3; i++) nvin[i] = w_r[4 + i];
    end else begin
      nflip = 1'b0;
    end
  end

  tts_norm u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (nstart_r),
    .flip    (nflip),
    .vin     (nvin),
    .prod    (prod),
    .mul_req (norm_req),
    .stat    (nstat),
    .q       (nq)
  );

  // hold the finished word until the sink takes it
  assign load_out = (state_r == T_FINISH) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      slot_r       <= '0;
      pv_r         <= 1'b0;
      nstart_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      nstart_r <= nstart_nxt;
      pv_r     <= issue;
      pidx_r   <= pc_r;
      if (issue) pc_r <= pc_r + PCW'(1);

      // accumulate product pairs
      if (pv_r) begin
        if (!pidx_r[0]) acc_r <= VW'(prod);
        else w_r[pidx_r[PCW-1:1]] <= acc_r - VW'(prod);
      end

      if (load_out) begin
        out_tvalid_r <= 1'b1;
        out_tuser_r  <= degen_r;
        out_tdata_r  <= degen_r ? '0 :
                        {n_r[2], n_r[1], n_r[0], b_r[2], b_r[1], b_r[0],
                         t_r[2], t_r[1], t_r[0]};
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        T_IDLE: begin
          if (accept) begin
            if (slot_r == 2'd0 || slot_r == 2'd1) begin
              for (int i = 0; i < 3; i++) hp_r[3 * slot_r + i] <= f_pos[i];
              ht_r[2 * slot_r]     <= f_u;
              ht_r[2 * slot_r + 1] <= f_v;
              slot_r <= slot_r + 2'd1;
            end else begin
              // third vertex: form edges and texture deltas, start the products
              for (int i = 0; i < 3; i++) begin
                e1_r[i] <= DW'($signed(hp_r[3 + i])) - DW'($signed(hp_r[i]));
                e2_r[i] <= DW'(f_pos[i]) - DW'($signed(hp_r[i]));
              end
              du1_r   <= DW'($signed(ht_r[2])) - DW'($signed(ht_r[0]));
              dv1_r   <= DW'($signed(ht_r[3])) - DW'($signed(ht_r[1]));
              du2_r   <= DW'(f_u) - DW'($signed(ht_r[0]));
              dv2_r   <= DW'(f_v) - DW'($signed(ht_r[1]));
              slot_r  <= '0;
              pc_r    <= '0;
              degen_r <= 1'b0;
              state_r <= T_PROD;
            end
          end
        end
        T_PROD: begin
          if (!issue) begin
            // last pair stored this cycle; det was stored long before
            if (w_r[0] == '0) begin
              degen_r <= 1'b1;
              state_r <= T_FINISH;
            end else begin
              state_r <= T_NORM_T;
            end
          end
        end
        T_NORM_T: begin
          if (nstat.done) begin
            if (nstat.zero) begin
              degen_r <= 1'b1;
              state_r <= T_FINISH;
            end else begin
              t_r     <= nq;
              state_r <= T_NORM_B;
            end
          end
        end
        T_NORM_B: begin
          if (nstat.done) begin
            if (nstat.zero) begin
              degen_r <= 1'b1;
              state_r <= T_FINISH;
            end else begin
              b_r     <= nq;
              state_r <= T_PROD_N;
            end
          end
        end
        T_PROD_N: begin
          if (!issue) begin
            state_r <= T_NORM_N;
          end
        end
        T_NORM_N: begin
          if (nstat.done) begin
            if (nstat.zero) degen_r <= 1'b1;
            n_r     <= nq;
            state_r <= T_FINISH;
          end
        end
        T_FINISH: begin
          if (load_out) state_r <= T_IDLE;
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  // a degenerate word carries only zero vectors
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate word with non-zero vectors");

  // the first tangent component stays within one in Q2.14
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd16384) &&
                   ($signed(out_tdata[15:0]) >= -16'sd16384))
    else $error("tangent component out of range");

  // the vertex slot never reaches three
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r != 2'd3)
    else $error("vertex slot overflow");

  // the sequencer issues no product while the normaliser holds the multiplier
  a_no_issue_in_norm: assert property (@(posedge clk) disable iff (!rst_n)
    norm_busy |-> !issue)
    else $error("product issued during normalisation");
`endif

endmodule

>>> sv/tts_mul.sv
// Shared signed multiplier with a registered product.
module tts_mul (
  input  logic                            clk,
  input  tts_pkg::mul_req_t               req,
  output logic signed [tts_pkg::PW-1:0]   prod_r
);
  import tts_pkg::*;

  logic signed [PW-1:0] a_x;
  logic signed [PW-1:0] b_x;

  assign a_x = PW'(req.a);
  assign b_x = PW'(req.b);

  always_ff @(posedge clk) begin
    prod_r <= a_x * b_x;
  end

endmodule

>>> sv/tts_norm.sv
// Iterative normaliser: common shift, sum of squares, square root and divide.
module tts_norm (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           flip,
  input  tts_pkg::vec_t                  vin [3],
  input  logic signed [tts_pkg::PW-1:0]  prod,
  output tts_pkg::mul_req_t              mul_req,
  output tts_pkg::norm_stat_t            stat,
  output tts_pkg::comp_t                 q [3]
);
  import tts_pkg::*;

  typedef enum logic [6:0] {
    N_IDLE  = 7'b0000001,
    N_SHIFT = 7'b0000010,
    N_SQ    = 7'b0000100,
    N_ROOT  = 7'b0001000,
    N_LOAD  = 7'b0010000,
    N_DIV   = 7'b0100000,
    N_DONE  = 7'b1000000
  } nstate_t;

  nstate_t          state_r;
  logic [VW-1:0]    m_r [3];
  logic             neg_r [3];
  logic             flip_r;
  logic             zero_r;
  logic [3:0]       cnt_r;
  logic [1:0]       ci_r;
  logic [SUMW-1:0]  sum_r;
  logic [SUMW-1:0]  rem_r;
  logic [SUMW-1:0]  res_r;
  logic [SUMW-1:0]  bit_r;
  logic [NUMW-1:0]  num_r;
  logic [NUMW-1:0]  den_r;
  logic [OW-1:0]    qv_r;
  comp_t            q_r [3];

  logic [VW-1:0]    or_all;
  logic [SUMW-1:0]  sum_nxt;
  logic [SUMW-1:0]  trial;
  logic [LENW-1:0]  len;
  logic             qbit;
  logic [OW-1:0]    qf;
  logic [OW-1:0]    qc;

  assign or_all  = m_r[0] | m_r[1] | m_r[2];
  assign sum_nxt = sum_r + prod[SUMW-1:0];
  assign trial   = res_r + bit_r;
  assign len     = res_r[LENW-1:0];
  assign qbit    = (num_r >= den_r);
  assign qf      = {qv_r[OW-2:0], qbit};
  assign qc      = (qf > OW'(UNIT)) ? OW'(UNIT) : qf;

  always_comb begin
    mul_req.a = '0;
    mul_req.b = '0;
    if (state_r == N_SQ && cnt_r < 4'd3) begin
      mul_req.a = DW'(m_r[cnt_r[1:0]][RW-1:0]);
      mul_req.b = DW'(m_r[cnt_r[1:0]][RW-1:0]);
    end
  end

  assign stat.done = (state_r == N_DONE);
  assign stat.zero = zero_r;
  assign q         = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      zero_r  <= 1'b0;
    end else begin
      unique case (state_r)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg_r[i] <= vin[i][VW-1];
              m_r[i]   <= vin[i][VW-1] ? VW'(-vin[i]) : vin[i];
            end
            flip_r  <= flip;
            zero_r  <= 1'b0;
            state_r <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          // bring the largest magnitude to exactly RW significant bits
          if (or_all == '0) begin
            zero_r  <= 1'b1;
            state_r <= N_DONE;
          end else if (|or_all[VW-1:RW]) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else if (!or_all[RW-1]) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else begin
            cnt_r   <= '0;
            sum_r   <= '0;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r != 4'd0) sum_r <= sum_nxt;
          if (cnt_r == 4'd3) begin
            rem_r   <= sum_nxt;
            res_r   <= '0;
            bit_r   <= SUMW'(1) << (SUMW - 2);
            state_r <= N_ROOT;
          end
        end
        N_ROOT: begin
          if (bit_r != '0) begin
            if (rem_r >= trial) begin
              rem_r <= rem_r - trial;
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end else begin
            ci_r    <= '0;
            state_r <= N_LOAD;
          end
        end
        N_LOAD: begin
          num_r   <= NUMW'({m_r[ci_r][RW-1:0], {FRACW{1'b0}}}) + NUMW'(len >> 1);
          den_r   <= NUMW'({len, {(OW-1){1'b0}}});
          qv_r    <= '0;
          cnt_r   <= '0;
          state_r <= N_DIV;
        end
        N_DIV: begin
          if (qbit) num_r <= num_r - den_r;
          den_r <= den_r >> 1;
          qv_r  <= qf;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(OW - 1)) begin
            q_r[ci_r] <= (neg_r[ci_r] ^ flip_r) ? comp_t'(-qc) : comp_t'(qc);
            if (ci_r == 2'd2) begin
              state_r <= N_DONE;
            end else begin
              ci_r    <= ci_r + 2'd1;
              state_r <= N_LOAD;
            end
          end
        end
        N_DONE: begin
          state_r <= N_IDLE;
        end
        default: begin
          state_r <= N_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sim/tb_triangle_tangent_space.sv
// Self-checking testbench for the triangle tangent-space block, with predictor and checker.
`timescale 1ns / 1ps

module tb_triangle_tangent_space;
  import tts_pkg::*;

  localparam int IDLE_PCT  = 36;
  localparam int HOLD_LONG = 1500;  // receiver hold-off; longer than several triangles

  typedef struct {
    comp_t tan[3];
    comp_t bit_v[3];
    comp_t nrm[3];
    bit    degen;
  } frame_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic         out_tuser;

  // Predictor state: first two vertices of the triangle in flight
  logic signed [31:0] held_pos[6];
  logic signed [31:0] held_uv[4];
  int unsigned        slot;

  frame_t frame_q[$];
  int     errors = 0;
  bit     calm = 1'b0;        // no idling on either side while set
  bit     hold_start = 1'b0;  // request a long receiver hold-off

  triangle_tangent_space dut (.*);

  always #5 clk = ~clk;

  // Floor square root, bit by bit.
  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Normalise an exact vector to Q2.14; return 0 for the zero vector.
  function automatic bit unit_vec(input logic signed [127:0] v[3], input bit flip,
                                  output comp_t o[3]);
    logic [127:0] m[3];
    bit           neg[3];
    int           maxl, k, i;
    logic [63:0]  r[3], sum, l, q;
    maxl = 0;
    sum = 0;
    for (i = 0; i < 3; i++) begin
      neg[i] = v[i][127];
      m[i] = neg[i] ? -v[i] : v[i];
      for (k = 127; k >= 0; k--)
        if (m[i][k]) begin
          if (k + 1 > maxl) maxl = k + 1;
          break;
        end
    end
    if (maxl == 0) return 1'b0;
    for (i = 0; i < 3; i++) begin
      if (maxl > 30) r[i] = 64'(m[i] >> (maxl - 30));
      else r[i] = 64'(m[i] << (30 - maxl));
      sum += r[i] * r[i];
    end
    l = isqrt(sum);
    for (i = 0; i < 3; i++) begin
      q = (r[i] * UNIT + l / 2) / l;
      if (q > UNIT) q = UNIT;
      o[i] = (neg[i] != flip) ? -comp_t'(q) : comp_t'(q);
    end
    return 1'b1;
  endfunction

  // Advance the predictor by one vertex; queue a frame on the third.
  task automatic predict_vertex(input logic [159:0] w);
    logic signed [31:0]  f[5];
    logic signed [127:0] e1[3], e2[3], du1, dv1, du2, dv2, det;
    logic signed [127:0] tv[3], bv[3], nv[3];
    frame_t              fr;
    bit                  ok, flip;
    int                  i;
    for (i = 0; i < 5; i++) f[i] = w[32*i +: 32];
    if (slot < 2) begin
      for (i = 0; i < 3; i++) held_pos[slot*3 + i] = f[i];
      held_uv[slot*2] = f[3];
      held_uv[slot*2 + 1] = f[4];
      slot++;
      return;
    end
    slot = 0;
    for (i = 0; i < 3; i++) begin
      e1[i] = 128'(held_pos[3+i]) - 128'(held_pos[i]);
      e2[i] = 128'(f[i]) - 128'(held_pos[i]);
    end
    du1 = 128'(held_uv[2]) - 128'(held_uv[0]);
    dv1 = 128'(held_uv[3]) - 128'(held_uv[1]);
    du2 = 128'(f[3]) - 128'(held_uv[0]);
    dv2 = 128'(f[4]) - 128'(held_uv[1]);
    det = du1 * dv2 - du2 * dv1;
    ok = det != 0;
    flip = det[127];
    if (ok) begin
      for (i = 0; i < 3; i++) begin
        tv[i] = dv2 * e1[i] - dv1 * e2[i];
        bv[i] = du1 * e2[i] - du2 * e1[i];
      end
      ok = unit_vec(tv, flip, fr.tan) && unit_vec(bv, flip, fr.bit_v);
    end
    if (ok) begin
      nv[0] = 128'(fr.tan[1]) * 128'(fr.bit_v[2]) - 128'(fr.tan[2]) * 128'(fr.bit_v[1]);
      nv[1] = 128'(fr.tan[2]) * 128'(fr.bit_v[0]) - 128'(fr.tan[0]) * 128'(fr.bit_v[2]);
      nv[2] = 128'(fr.tan[0]) * 128'(fr.bit_v[1]) - 128'(fr.tan[1]) * 128'(fr.bit_v[0]);
      ok = unit_vec(nv, 1'b0, fr.nrm);
    end
    if (!ok)
      for (i = 0; i < 3; i++) begin
        fr.tan[i] = '0;
        fr.bit_v[i] = '0;
        fr.nrm[i] = '0;
      end
    fr.degen = !ok;
    frame_q.push_back(fr);
  endtask

  // Offer one vertex word, after an optional idle gap; return once it is taken.
  task automatic send_vertex(input logic [31:0] px, py, pz, u, v);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < IDLE_PCT) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {v, u, pz, py, px};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    predict_vertex(in_tdata);
  endtask

  task automatic send_tri(input logic [31:0] a[5], b[5], c[5]);
    send_vertex(a[0], a[1], a[2], a[3], a[4]);
    send_vertex(b[0], b[1], b[2], b[3], b[4]);
    send_vertex(c[0], c[1], c[2], c[3], c[4]);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;  // full range, every bit
      2:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      3:       return $urandom_range(0, 15) - 8;  // tiny
      default: return $urandom_range(0, 32'h001fffff) - 32'h00100000;
    endcase
  endfunction

  task automatic rnd_tri();
    logic [31:0] a[5], b[5], c[5];
    int i;
    for (i = 0; i < 5; i++) begin
      a[i] = rnd_coord();
      b[i] = rnd_coord();
      c[i] = rnd_coord();
    end
    case ($urandom_range(0, 19))
      0: begin b[3] = a[3]; c[3] = a[3]; end  // zero determinant
      1: begin b[0:2] = a[0:2]; c[0:2] = a[0:2]; end  // zero-area positions
      2: begin  // colinear positions
        b[1] = a[1]; c[1] = a[1]; b[2] = a[2]; c[2] = a[2];
      end
      default: ;
    endcase
    send_tri(a, b, c);
  endtask

  task automatic test_directed();
    localparam logic [31:0] ONE = 32'h00010000, MX = 32'h7fffffff, MN = 32'h80000000;
    send_tri('{0, 0, 0, 0, 0}, '{ONE, 0, 0, ONE, 0}, '{0, ONE, 0, 0, ONE});
    // negative determinant flips both vectors
    send_tri('{0, 0, 0, 0, 0}, '{ONE, 0, 0, 0, ONE}, '{0, ONE, 0, ONE, 0});
    // zero determinant
    send_tri('{0, 0, 0, 5, 5}, '{ONE, 0, 0, 5, 5}, '{0, ONE, 0, 5, 5});
    // coincident positions: tangent of zero length
    send_tri('{7, 7, 7, 0, 0}, '{7, 7, 7, ONE, 0}, '{7, 7, 7, 0, ONE});
    // colinear positions: normal of zero length
    send_tri('{0, 0, 0, 0, 0}, '{ONE, 0, 0, ONE, 0}, '{2*ONE, 0, 0, 0, ONE});
    // field extremes
    send_tri('{MN, MN, MN, MN, MN}, '{MX, MN, MX, MX, MN}, '{MN, MX, MX, MN, MX});
    send_tri('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
             '{0, 0, 0, 0, 0},
             '{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555});
    // tiny vectors: magnitudes are shifted up before the square root
    send_tri('{0, 0, 0, 0, 0}, '{1, 0, 1, 1, 0}, '{0, 1, 0, 0, 1});
  endtask

  task automatic test_random(input int n_tri);
    int k;
    for (k = 0; k < n_tri; k++) begin
      calm = (k >= n_tri / 3) && (k < n_tri / 3 + 40);
      rnd_tri();
    end
    calm = 1'b0;
  endtask

  // Hold the receiver off while vertices keep coming, so the input stalls.
  task automatic test_backpressure();
    int k;
    hold_start = 1'b1;
    calm = 1'b1;
    for (k = 0; k < 6; k++) rnd_tri();
    calm = 1'b0;
  endtask

  // Pause the sender until every frame is out, then resume.
  task automatic test_drain();
    int k;
    for (k = 0; k < 3; k++) rnd_tri();
    in_tvalid <= 1'b0;
    wait (frame_q.size() == 0);
    @(posedge clk);
    for (k = 0; k < 3; k++) rnd_tri();
  endtask

  // Receiver: random idling, long hold-off on request, counted here.
  always @(posedge clk) begin
    int hold_left;
    if (hold_start) begin
      hold_left = HOLD_LONG;
      hold_start = 1'b0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Capture the output word mid-cycle; check it at the edge that takes it.
  logic         out_fire = 1'b0;
  logic [143:0] out_word;
  logic         out_flag;

  always @(negedge clk) begin
    out_fire <= rst_n && out_tvalid && out_tready;
    out_word <= out_tdata;
    out_flag <= out_tuser;
  end

  task automatic compare_field(input string name, input int idx, input int want, got);
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s[%0d] mismatch: expected %0d, got %0d", $realtime, name, idx,
                 want, got);
    end
  endtask

  always @(posedge clk) begin
    frame_t fr;
    int i;
    if (out_fire) begin
      if (frame_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: output word with nothing expected", $realtime);
      end else begin
        fr = frame_q.pop_front();
        for (i = 0; i < 3; i++) begin
          compare_field("tangent", i, fr.tan[i], $signed(out_word[16*i +: 16]));
          compare_field("bitangent", i, fr.bit_v[i], $signed(out_word[16*(i+3) +: 16]));
          compare_field("face_normal", i, fr.nrm[i], $signed(out_word[16*(i+6) +: 16]));
        end
        compare_field("degenerate", 0, fr.degen, out_flag);
      end
    end
  end

  initial begin
    slot = 0;
    foreach (held_pos[i]) held_pos[i] = 0;
    foreach (held_uv[i]) held_uv[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(200);
    test_backpressure();
    test_drain();
    test_random(210);
    in_tvalid <= 1'b0;
    wait (frame_q.size() == 0);
    repeat (500) @(posedge clk);
    if (errors == 0 && frame_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung block.
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
